// ----- design/bfi_pkg.sv -----
// ----------------------------------------------------------------------------
// bfi_pkg: shared constants, types and helpers
// Sizes, register indexes and the memory request word for the bloom filter.
// ----------------------------------------------------------------------------
package bfi_pkg;

  localparam int MAX_BITS_LOG2 = 16;
  localparam int MAX_HASHES    = 16;
  localparam int MIN_BITS_LOG2 = 9;

  localparam int POS_W       = MAX_BITS_LOG2;
  localparam int BYTE_AW     = POS_W - 3;
  localparam int ARRAY_BYTES = 1 << BYTE_AW;
  localparam int CNT_W       = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int CFG_W       = 5;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic REG_BIT_COUNT_LOG2 = 1'b0;
  localparam logic REG_HASH_COUNT     = 1'b1;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic               rd;
    logic               set;
    logic [BYTE_AW-1:0] addr;
    logic [2:0]         bit_sel;
  } mem_req_t;

  function automatic logic [CFG_W-1:0] eff_log2(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] s;
    s = cfg;
    if (s < CFG_W'(MIN_BITS_LOG2)) s = CFG_W'(MIN_BITS_LOG2);
    if (s > CFG_W'(MAX_BITS_LOG2)) s = CFG_W'(MAX_BITS_LOG2);
    return s;
  endfunction

  function automatic logic [POS_W-1:0] size_mask(input logic [CFG_W-1:0] lg);
    logic [POS_W:0] m;
    m = ({{POS_W{1'b0}}, 1'b1} << lg) - {{POS_W{1'b0}}, 1'b1};
    return m[POS_W-1:0];
  endfunction

  // number of probes less one
  function automatic logic [CNT_W-1:0] probe_last(input logic [CFG_W-1:0] cfg);
    logic [CFG_W:0] n;
    n = {1'b0, cfg};
    if (n < (CFG_W+1)'(1)) n = (CFG_W+1)'(1);
    if (n > (CFG_W+1)'(MAX_HASHES)) n = (CFG_W+1)'(MAX_HASHES);
    n = n - (CFG_W+1)'(1);
    return n[CNT_W-1:0];
  endfunction

endpackage

// ----- design/bfi_mem.sv -----
// ----------------------------------------------------------------------------
// bfi_mem: filter bit array
// Byte-wide memory with read-modify-write bit set, forwarding of the last
// write, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bfi_mem
  import bfi_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  mem_req_t       req,
  output logic [7:0]     rd_data,
  output logic           clearing
);

  logic [7:0]         mem [ARRAY_BYTES];
  logic [BYTE_AW-1:0] clr_addr;
  logic               p_set;
  logic [BYTE_AW-1:0] p_addr;
  logic [2:0]         p_bit;
  logic               f_valid;
  logic [BYTE_AW-1:0] f_addr;
  logic [7:0]         f_data;
  logic [7:0]         base;
  logic [7:0]         merged;

  always_comb begin
    base   = (f_valid && f_addr == p_addr) ? f_data : rd_data;
    merged = base | (8'h01 << p_bit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      p_set    <= 1'b0;
      f_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        mem[clr_addr] <= 8'h00;
        clr_addr      <= clr_addr + BYTE_AW'(1);
        if (clr_addr == {BYTE_AW{1'b1}}) clearing <= 1'b0;
      end else if (p_set) begin
        mem[p_addr] <= merged;
      end
      if (req.rd) begin
        rd_data <= mem[req.addr];
      end
      p_set   <= req.rd && req.set;
      p_addr  <= req.addr;
      p_bit   <= req.bit_sel;
      f_valid <= p_set;
      f_addr  <= p_addr;
      f_data  <= merged;
    end
  end

endmodule

// ----- design/bloom_filter_insert.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_insert: bloom filter builder with double hashing
// Adds key fingerprints to a power-of-two bit array and reads bytes back.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall   action, key_fingerprint, byte_index
//   out      out  out_valid / out_stall read_data
//   cfg      in   apb (psel, penable)   bit_count_log2 @0, hash_count @4
//
// Add word: PROBE, DRAIN, DONE; probe count being hash_count held to
// 1..16 (one probe a cycle through the shared position adder and the single
// read-modify-write memory port).
// Read word: READ, RWAIT, DONE. One word in flight at a time.
// After reset the array is swept to zero, all 8192 bytes, with in_stall high.
// A waiting result does not block the next accept; it blocks only the next
// word's own completion.
// ----------------------------------------------------------------------------
module bloom_filter_insert
  import bfi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [63:0]         key_fingerprint,
  input  logic [BYTE_AW-1:0]  byte_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          read_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  typedef enum logic [2:0] {IDLE, PROBE, DRAIN, READ, RWAIT, DONE} state_t;

  state_t             state;
  logic [CFG_W-1:0]   bit_count_log2;
  logic [CFG_W-1:0]   hash_count;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   step;
  logic [POS_W-1:0]   mask;
  logic [CNT_W-1:0]   cnt;
  logic [BYTE_AW-1:0] bidx;
  logic               rd_ok;
  logic [7:0]         res;
  logic [POS_W-1:0]   probe_pos;
  logic               in_range;
  logic               out_free;
  logic               clearing;
  logic [7:0]         mem_data;
  mem_req_t           req;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count_log2 <= CFG_W'(16);
      hash_count     <= CFG_W'(6);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_BIT_COUNT_LOG2: bit_count_log2 <= pwdata[CFG_W-1:0];
        REG_HASH_COUNT:     hash_count     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BIT_COUNT_LOG2: prdata = {{(PDATA_W-CFG_W){1'b0}}, bit_count_log2};
      REG_HASH_COUNT:     prdata = {{(PDATA_W-CFG_W){1'b0}}, hash_count};
      default:            prdata = '0;
    endcase
  end

  assign in_stall  = (state != IDLE) || clearing;
  assign out_free  = !out_valid || !out_stall;
  assign probe_pos = pos & mask;
  assign in_range  = (bidx & ~mask[POS_W-1:3]) == '0;

  always_comb begin
    req = '0;
    case (state)
      PROBE: begin
        req.rd      = 1'b1;
        req.set     = 1'b1;
        req.addr    = probe_pos[POS_W-1:3];
        req.bit_sel = probe_pos[2:0];
      end
      READ: begin
        req.rd   = in_range;
        req.addr = bidx;
      end
      default: ;
    endcase
  end

  bfi_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (mem_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != DONE) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid && !in_stall) begin
            pos  <= key_fingerprint[POS_W-1:0];
            step <= key_fingerprint[32+POS_W-1:32] | POS_W'(1);
            mask <= size_mask(eff_log2(bit_count_log2));
            cnt  <= probe_last(hash_count);
            bidx <= byte_index;
            state <= (action == ACT_ADD) ? PROBE : READ;
          end
        end
        PROBE: begin
          pos <= pos + step;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) state <= DRAIN;
        end
        DRAIN: begin
          res   <= 8'h00;
          state <= DONE;
        end
        READ: begin
          rd_ok <= in_range;
          state <= RWAIT;
        end
        RWAIT: begin
          res   <= rd_ok ? mem_data : 8'h00;
          state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            read_data <= res;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- design/bfi_checker.sv -----
// ----------------------------------------------------------------------------
// bfi_checker: port-level checks for the bloom filter
// Watches the top-level ports only; bound to bloom_filter_insert.
// ----------------------------------------------------------------------------
module bfi_checker
  import bfi_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [7:0]          read_data,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [PADDR_W-1:0]  paddr,
  input logic [PDATA_W-1:0]  pwdata,
  input logic [PDATA_W-1:0]  prdata,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("word accepted during clearing sweep");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a word in progress");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_BIT_COUNT_LOG2
    |=> rst || paddr[2] != REG_BIT_COUNT_LOG2 ||
        prdata == {{(PDATA_W-CFG_W){1'b0}}, $past(pwdata[CFG_W-1:0])})
    else $error("size register read-back mismatch");

endmodule

bind bloom_filter_insert bfi_checker u_bfi_checker (.*);
